// ----- rtl/core/rrt_extend_step_defines.svh -----
// Assertion macros for the RRT extension block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef RRT_EXTEND_STEP_DEFINES_SVH
`define RRT_EXTEND_STEP_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define RRT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define RRT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRT_ASSERT(name, clk, rst_n, prop, msg)
`define RRT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ----- rtl/core/rrt_pkg.sv -----
// Shared types and codes for the RRT extension block.
// No dependencies; imported by the top level.
package rrt_pkg;

    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 3;
    localparam int IDX_OUT_W = 10;
    localparam int CFG_IDX_W = 3;

    // Request opcodes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE   = 2'd0,
        ACT_READ     = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_READ_ALT = 2'd3
    } action_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_BLOCKED  = 3'd1,
        ST_GOAL     = 3'd2,
        ST_FULL     = 3'd3,
        ST_SOLVED   = 3'd4,
        ST_PATH     = 3'd5,
        ST_NO_PATH  = 3'd6,
        ST_CLEARED  = 3'd7
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X  = 3'd0,
        CFG_START_Y  = 3'd1,
        CFG_GOAL_X   = 3'd2,
        CFG_GOAL_Y   = 3'd3,
        CFG_RADIUS   = 3'd4,
        CFG_WALL_X   = 3'd5,
        CFG_GAP_LOW  = 3'd6,
        CFG_GAP_HIGH = 3'd7
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_SEED,
        S_SCAN,
        S_BEST,
        S_BEST_CAP,
        S_RR_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_ST_MUL,
        S_ST_MULW,
        S_ST_DIV,
        S_ST_DIVW,
        S_SEG_START,
        S_SEG_MULW,
        S_SEG_DIV,
        S_SEG_DIVW,
        S_SEG_DONE,
        S_GOAL_MUL,
        S_GOAL_MULW,
        S_PATH_RD,
        S_PATH_CAP,
        S_DONE
    } state_t;

endpackage

// ----- rtl/core/rrt_extend_step.sv -----
// RRT extension block top level: sequencer, registers and unit hookup.
// Depends on rrt_pkg, rrt_node_mem, rrt_mac, rrt_div, rrt_isqrt and the defines header.
//
// Grows a 2-D rapidly-exploring random tree in unsigned fixed point, one request at a
// time; s_ready is high only while the sequencer is idle, and a finished result waits in
// the output register without holding off the next request. A sample request scans every
// stored node for the nearest one (one stored node read per cycle through the node memory
// port and the shared multiply-add unit), then takes a square root and two divisions when
// the sample is pulled in, plus up to two more divisions for the wall tests. The node
// store has no reset; node_count bounds what is ever read.
`include "rrt_extend_step_defines.svh"

module rrt_extend_step
    import rrt_pkg::*;
#(
    parameter int MAX_NODES       = 1024,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [COORD_FRAC_BITS:0] cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ACTION_W-1:0]      s_action,
    input  logic [COORD_FRAC_BITS:0] s_sample_x,
    input  logic [COORD_FRAC_BITS:0] s_sample_y,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [COORD_FRAC_BITS:0] m_point_x,
    output logic [COORD_FRAC_BITS:0] m_point_y,
    output logic [IDX_OUT_W-1:0]     m_node_index,
    output logic                     m_last
);

    localparam int CW    = COORD_FRAC_BITS + 1;
    localparam int IW    = $clog2(MAX_NODES);
    localparam int CNTW  = $clog2(MAX_NODES + 1);
    localparam int SQW   = 2 * CW + 1;
    localparam int RW    = CW + 1;
    localparam int DIVN  = 2 * CW;
    localparam int DIVD  = CW + 1;
    localparam int CYW   = CW + 2;
    localparam int MEMW  = IW + 2 * CW;

    localparam longint ONE_L = longint'(1) << COORD_FRAC_BITS;
    localparam logic [CW-1:0] RST_GOAL   = CW'(ONE_L);
    localparam logic [CW-1:0] RST_WALL   = CW'(ONE_L / 2);
    localparam logic [CW-1:0] RST_RADIUS = CW'((ONE_L + 5) / 10);
    localparam logic [CW-1:0] RST_GAP_LO = CW'((2 * ONE_L + 5) / 10);
    localparam logic [CW-1:0] RST_GAP_HI = CW'((8 * ONE_L + 5) / 10);

    // Configuration registers.
    logic [CW-1:0] start_x_reg, start_y_reg, goal_x_reg, goal_y_reg;
    logic [CW-1:0] radius_reg, wall_x_reg, gap_low_reg, gap_high_reg;

    // Tree state.
    state_t          state_reg, state_next;
    logic [CNTW-1:0] node_count_reg;
    logic            solved_reg, at_goal_reg;
    logic [IW-1:0]   goal_parent_reg, cursor_reg;

    // Working registers.
    logic [CW-1:0]   sx_reg, sy_reg, base_x_reg, base_y_reg, nx_reg, ny_reg;
    logic [CNTW-1:0] issue_reg;
    logic            rd_v1_reg;
    logic [IW-1:0]   idx1_reg, idx2_reg, idx3_reg, best_reg, ni_reg;
    logic [SQW-1:0]  bd_reg, rr_reg, mul_reg;
    logic [RW-1:0]   dist_reg;
    logic            axis_reg, seg_goal_reg, seg_free_reg;

    // Staged result and output register.
    logic [STATUS_W-1:0]  res_status_reg;
    logic [CW-1:0]        res_x_reg, res_y_reg;
    logic [IDX_OUT_W-1:0] res_idx_reg;
    logic                 res_last_reg;
    logic                 m_valid_reg, m_last_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [CW-1:0]        m_x_reg, m_y_reg;
    logic [IDX_OUT_W-1:0] m_idx_reg;

    // Unit hookup.
    logic            mem_wr_en, mem_rd_en;
    logic [IW-1:0]   mem_wr_addr, mem_rd_addr;
    logic [MEMW-1:0] mem_wr_data, mem_rd_data;
    logic [CW-1:0]   rd_x, rd_y;
    logic [IW-1:0]   rd_parent;
    logic            mac_vi, mac_vo;
    logic [CW-1:0]   mac_a, mac_b, mac_c, mac_d;
    logic [SQW-1:0]  mac_sum;
    logic            div_start, div_done;
    logic [DIVN-1:0] div_num, div_quot;
    logic [DIVD-1:0] div_den;
    logic            sqrt_start, sqrt_done;
    logic [RW-1:0]   sqrt_root;

    // Datapath helpers.
    logic                  s_acc, scan_issue;
    logic [CNTW-1:0]       count_inc;
    logic [IW-1:0]         last_idx;
    logic [CW-1:0]         scan_dx, scan_dy;
    logic [CW-1:0]         st_base, st_s, st_delta, st_new, st_q;
    logic                  st_ge;
    logic [CW-1:0]         seg_x2, seg_y2, seg_m1, seg_m2, seg_den;
    logic                  seg_cross, seg_neg, seg_free_calc;
    logic signed [CYW-1:0] seg_y2_ext, seg_q_ext, seg_cy, gap_lo_ext, gap_hi_ext;
    logic [CW-1:0]         goal_dx, goal_dy;

    assign {rd_parent, rd_x, rd_y} = mem_rd_data;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_valid && s_ready;
    assign count_inc = node_count_reg + CNTW'(1);
    assign last_idx  = IW'(node_count_reg - CNTW'(1));

    // Arithmetic around the shared units.
    always_comb begin
        scan_issue = (state_reg == S_SCAN) && (issue_reg < node_count_reg);
        scan_dx = (sx_reg >= rd_x) ? sx_reg - rd_x : rd_x - sx_reg;
        scan_dy = (sy_reg >= rd_y) ? sy_reg - rd_y : rd_y - sy_reg;

        st_base  = axis_reg ? base_y_reg : base_x_reg;
        st_s     = axis_reg ? sy_reg : sx_reg;
        st_ge    = st_s >= st_base;
        st_delta = st_ge ? st_s - st_base : st_base - st_s;
        st_q     = div_quot[CW-1:0];
        st_new   = st_ge ? st_base + st_q : st_base - st_q;

        seg_x2    = seg_goal_reg ? goal_x_reg : base_x_reg;
        seg_y2    = seg_goal_reg ? goal_y_reg : base_y_reg;
        seg_cross = (nx_reg != wall_x_reg) && (seg_x2 != wall_x_reg)
                    && ((nx_reg > wall_x_reg) != (seg_x2 > wall_x_reg));
        seg_m1  = (wall_x_reg >= seg_x2) ? wall_x_reg - seg_x2 : seg_x2 - wall_x_reg;
        seg_m2  = (ny_reg >= seg_y2) ? ny_reg - seg_y2 : seg_y2 - ny_reg;
        seg_den = (nx_reg >= seg_x2) ? nx_reg - seg_x2 : seg_x2 - nx_reg;
        seg_neg = (wall_x_reg < seg_x2) ^ (ny_reg < seg_y2) ^ (nx_reg < seg_x2);
        seg_y2_ext = signed'({2'b00, seg_y2});
        seg_q_ext  = signed'({2'b00, div_quot[CW-1:0]});
        seg_cy     = seg_neg ? seg_y2_ext - seg_q_ext : seg_y2_ext + seg_q_ext;
        gap_lo_ext = signed'({2'b00, gap_low_reg});
        gap_hi_ext = signed'({2'b00, gap_high_reg});
        seg_free_calc = (seg_cy > gap_hi_ext) || (seg_cy < gap_lo_ext);

        goal_dx = (nx_reg >= goal_x_reg) ? nx_reg - goal_x_reg : goal_x_reg - nx_reg;
        goal_dy = (ny_reg >= goal_y_reg) ? ny_reg - goal_y_reg : goal_y_reg - ny_reg;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (action_t'(s_action))
                        ACT_CLEAR: state_next = S_DONE;
                        ACT_SAMPLE: begin
                            if (solved_reg) begin
                                state_next = S_DONE;
                            end else if (node_count_reg == '0) begin
                                state_next = S_SEED;
                            end else if (node_count_reg >= CNTW'(MAX_NODES)) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_READ, ACT_READ_ALT: begin
                            if (!solved_reg || at_goal_reg) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_PATH_RD;
                            end
                        end
                    endcase
                end
            end
            S_SEED: state_next = S_SCAN;
            S_SCAN: begin
                if (mac_vo && idx3_reg == last_idx) begin
                    state_next = S_BEST;
                end
            end
            S_BEST:     state_next = S_BEST_CAP;
            S_BEST_CAP: state_next = S_RR_WAIT;
            S_RR_WAIT: begin
                if (mac_vo) begin
                    state_next = (bd_reg > mac_sum) ? S_SQRT_GO : S_SEG_START;
                end
            end
            S_SQRT_GO: state_next = S_SQRT_WAIT;
            S_SQRT_WAIT: begin
                if (sqrt_done) begin
                    state_next = S_ST_MUL;
                end
            end
            S_ST_MUL: state_next = S_ST_MULW;
            S_ST_MULW: begin
                if (mac_vo) begin
                    state_next = S_ST_DIV;
                end
            end
            S_ST_DIV: state_next = S_ST_DIVW;
            S_ST_DIVW: begin
                if (div_done) begin
                    state_next = axis_reg ? S_SEG_START : S_ST_MUL;
                end
            end
            S_SEG_START: state_next = seg_cross ? S_SEG_MULW : S_SEG_DONE;
            S_SEG_MULW: begin
                if (mac_vo) begin
                    state_next = S_SEG_DIV;
                end
            end
            S_SEG_DIV: state_next = S_SEG_DIVW;
            S_SEG_DIVW: begin
                if (div_done) begin
                    state_next = S_SEG_DONE;
                end
            end
            S_SEG_DONE: begin
                if (!seg_goal_reg && seg_free_reg) begin
                    state_next = S_GOAL_MUL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_GOAL_MUL: state_next = S_GOAL_MULW;
            S_GOAL_MULW: begin
                if (mac_vo) begin
                    state_next = (mac_sum < rr_reg) ? S_SEG_START : S_DONE;
                end
            end
            S_PATH_RD:  state_next = S_PATH_CAP;
            S_PATH_CAP: state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Unit controls and operand selection.
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = {best_reg, nx_reg, ny_reg};
        mem_rd_en   = 1'b0;
        mem_rd_addr = issue_reg[IW-1:0];
        mac_vi      = 1'b0;
        mac_a       = scan_dx;
        mac_b       = scan_dx;
        mac_c       = scan_dy;
        mac_d       = scan_dy;
        div_start   = 1'b0;
        div_num     = mul_reg[DIVN-1:0];
        div_den     = dist_reg;
        sqrt_start  = 1'b0;
        unique case (state_reg)
            S_SEED: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = {{IW{1'b0}}, start_x_reg, start_y_reg};
            end
            S_SCAN: begin
                mem_rd_en = scan_issue;
                mac_vi    = rd_v1_reg;
            end
            S_BEST: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = best_reg;
                mac_vi      = 1'b1;
                mac_a       = radius_reg;
                mac_b       = radius_reg;
                mac_c       = '0;
                mac_d       = '0;
            end
            S_SQRT_GO: sqrt_start = 1'b1;
            S_ST_MUL: begin
                mac_vi = 1'b1;
                mac_a  = st_delta;
                mac_b  = radius_reg;
                mac_c  = '0;
                mac_d  = '0;
            end
            S_ST_DIV: div_start = 1'b1;
            S_SEG_START: begin
                mac_vi = seg_cross;
                mac_a  = seg_m1;
                mac_b  = seg_m2;
                mac_c  = '0;
                mac_d  = '0;
            end
            S_SEG_DIV: begin
                div_start = 1'b1;
                div_den   = {1'b0, seg_den};
            end
            S_SEG_DONE: begin
                mem_wr_en   = !seg_goal_reg && seg_free_reg;
                mem_wr_addr = node_count_reg[IW-1:0];
            end
            S_GOAL_MUL: begin
                mac_vi = 1'b1;
                mac_a  = goal_dx;
                mac_b  = goal_dx;
                mac_c  = goal_dy;
                mac_d  = goal_dy;
            end
            S_PATH_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = cursor_reg;
            end
            default: begin
            end
        endcase
    end

    // Control state, configuration and tree bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            goal_x_reg      <= RST_GOAL;
            goal_y_reg      <= RST_GOAL;
            radius_reg      <= RST_RADIUS;
            wall_x_reg      <= RST_WALL;
            gap_low_reg     <= RST_GAP_LO;
            gap_high_reg    <= RST_GAP_HI;
            node_count_reg  <= '0;
            solved_reg      <= 1'b0;
            at_goal_reg     <= 1'b1;
            goal_parent_reg <= '0;
            cursor_reg      <= '0;
            issue_reg       <= '0;
            rd_v1_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v1_reg <= scan_issue;
            if (scan_issue) begin
                issue_reg <= issue_reg + CNTW'(1);
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_START_X:  start_x_reg  <= cfg_data;
                    CFG_START_Y:  start_y_reg  <= cfg_data;
                    CFG_GOAL_X:   goal_x_reg   <= cfg_data;
                    CFG_GOAL_Y:   goal_y_reg   <= cfg_data;
                    CFG_RADIUS:   radius_reg   <= cfg_data;
                    CFG_WALL_X:   wall_x_reg   <= cfg_data;
                    CFG_GAP_LOW:  gap_low_reg  <= cfg_data;
                    CFG_GAP_HIGH: gap_high_reg <= cfg_data;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    issue_reg <= '0;
                    if (s_acc) begin
                        unique case (action_t'(s_action))
                            ACT_CLEAR: begin
                                node_count_reg  <= '0;
                                solved_reg      <= 1'b0;
                                goal_parent_reg <= '0;
                                at_goal_reg     <= 1'b1;
                            end
                            ACT_READ, ACT_READ_ALT: begin
                                if (solved_reg && at_goal_reg) begin
                                    at_goal_reg <= 1'b0;
                                    cursor_reg  <= goal_parent_reg;
                                end
                            end
                            ACT_SAMPLE: begin
                            end
                        endcase
                    end
                end
                S_SEED: node_count_reg <= CNTW'(1);
                S_SEG_DONE: begin
                    if (!seg_goal_reg && seg_free_reg) begin
                        node_count_reg <= count_inc;
                    end else if (seg_goal_reg && seg_free_reg) begin
                        solved_reg      <= 1'b1;
                        goal_parent_reg <= ni_reg;
                        at_goal_reg     <= 1'b1;
                    end
                end
                S_PATH_CAP: begin
                    if (cursor_reg == '0) begin
                        at_goal_reg <= 1'b1;
                    end else begin
                        cursor_reg <= rd_parent;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working datapath registers and staged results.
    always_ff @(posedge aclk) begin
        idx1_reg <= issue_reg[IW-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;

        unique case (state_reg)
            S_IDLE: begin
                sx_reg       <= s_sample_x;
                sy_reg       <= s_sample_y;
                seg_goal_reg <= 1'b0;
                axis_reg     <= 1'b0;
                res_x_reg    <= '0;
                res_y_reg    <= '0;
                res_idx_reg  <= '0;
                res_last_reg <= 1'b0;
                unique case (action_t'(s_action))
                    ACT_CLEAR:  res_status_reg <= ST_CLEARED;
                    ACT_SAMPLE: res_status_reg <= solved_reg ? ST_SOLVED : ST_FULL;
                    ACT_READ, ACT_READ_ALT: begin
                        res_status_reg <= solved_reg ? ST_PATH : ST_NO_PATH;
                        if (solved_reg && at_goal_reg) begin
                            res_x_reg   <= goal_x_reg;
                            res_y_reg   <= goal_y_reg;
                            res_idx_reg <= IDX_OUT_W'(node_count_reg);
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (mac_vo && (idx3_reg == '0 || mac_sum < bd_reg)) begin
                    bd_reg   <= mac_sum;
                    best_reg <= idx3_reg;
                end
            end
            S_BEST_CAP: begin
                base_x_reg <= rd_x;
                base_y_reg <= rd_y;
            end
            S_RR_WAIT: begin
                rr_reg <= mac_sum;
                nx_reg <= sx_reg;
                ny_reg <= sy_reg;
            end
            S_SQRT_WAIT: dist_reg <= sqrt_root;
            S_ST_MULW, S_SEG_MULW: mul_reg <= mac_sum;
            S_ST_DIVW: begin
                if (div_done) begin
                    axis_reg <= 1'b1;
                    if (axis_reg) begin
                        ny_reg <= st_new;
                    end else begin
                        nx_reg <= st_new;
                    end
                end
            end
            S_SEG_START: seg_free_reg <= 1'b1;
            S_SEG_DIVW:  seg_free_reg <= seg_free_calc;
            S_SEG_DONE: begin
                res_x_reg <= nx_reg;
                res_y_reg <= ny_reg;
                if (!seg_goal_reg) begin
                    ni_reg         <= node_count_reg[IW-1:0];
                    res_status_reg <= seg_free_reg ? ST_ADDED : ST_BLOCKED;
                    res_idx_reg    <= seg_free_reg ? IDX_OUT_W'(node_count_reg)
                                                   : IDX_OUT_W'(best_reg);
                end else begin
                    res_status_reg <= seg_free_reg ? ST_GOAL : ST_ADDED;
                    res_idx_reg    <= IDX_OUT_W'(ni_reg);
                end
            end
            S_GOAL_MULW: begin
                if (mac_vo && mac_sum < rr_reg) begin
                    seg_goal_reg <= 1'b1;
                end
            end
            S_PATH_CAP: begin
                res_x_reg    <= rd_x;
                res_y_reg    <= rd_y;
                res_idx_reg  <= IDX_OUT_W'(cursor_reg);
                res_last_reg <= (cursor_reg == '0);
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_status_reg <= res_status_reg;
                    m_x_reg      <= res_x_reg;
                    m_y_reg      <= res_y_reg;
                    m_idx_reg    <= res_idx_reg;
                    m_last_reg   <= res_last_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_point_x    = m_x_reg;
    assign m_point_y    = m_y_reg;
    assign m_node_index = m_idx_reg;
    assign m_last       = m_last_reg;

    rrt_node_mem #(
        .DEPTH (MAX_NODES),
        .AW    (IW),
        .DW    (MEMW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rrt_mac #(
        .W (CW)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mac_vi),
        .a         (mac_a),
        .b         (mac_b),
        .c         (mac_c),
        .d         (mac_d),
        .out_valid (mac_vo),
        .sum       (mac_sum)
    );

    rrt_div #(
        .NW (DIVN),
        .DW (DIVD)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    rrt_isqrt #(
        .RW (RW)
    ) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   ({1'b0, bd_reg}),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // The tree never holds more nodes than the store has entries.
    `RRT_ASSERT(a_count_bound, aclk, aresetn, node_count_reg <= CNTW'(MAX_NODES), "node count overflow")
    // A solved tree points its goal at a stored node.
    `RRT_ASSERT(a_goal_parent, aclk, aresetn, solved_reg |-> (CNTW'(goal_parent_reg) < node_count_reg), "goal parent outside tree")
    // A divider result only arrives while the sequencer waits for it.
    `RRT_ASSERT(a_div_owner, aclk, aresetn, div_done |-> (state_reg == S_ST_DIVW || state_reg == S_SEG_DIVW), "stray divider result")
    // An accepted request always leaves the idle state.
    `RRT_ASSERT(a_accept_busy, aclk, aresetn, s_acc |=> (state_reg != S_IDLE), "request accepted without work")

endmodule

// ----- rtl/core/rrt_node_mem.sv -----
// Node store: one write port and one registered read port.
// No package dependencies.
module rrt_node_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 44
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Storage array with registered read data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/rrt_mac.sv -----
// Shared two-stage multiply-add unit: sum = a*b + c*d.
// No package dependencies.
module rrt_mac #(
    parameter int W = 17
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] c,
    input  logic [W-1:0] d,
    output logic         out_valid,
    output logic [2*W:0] sum
);

    logic [2*W-1:0] p1_reg, p2_reg;
    logic [2*W:0]   sum_reg;
    logic           v1_reg, v2_reg;

    // Valid pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Products, then their sum.
    always_ff @(posedge aclk) begin
        p1_reg  <= a * b;
        p2_reg  <= c * d;
        sum_reg <= {1'b0, p1_reg} + {1'b0, p2_reg};
    end

    assign out_valid = v2_reg;
    assign sum       = sum_reg;

endmodule

// ----- rtl/core/rrt_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// No package dependencies.
module rrt_div #(
    parameter int NW = 34,
    parameter int DW = 18
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    quot_reg;
    logic [DW-1:0]    rem_reg, den_reg;
    logic [DW:0]      shifted, diff;
    logic             fits;

    // One trial subtraction per step.
    always_comb begin
        shifted = {rem_reg, quot_reg[NW-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};
    end

    // Step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient shifts in from the bottom as the dividend shifts out the top.
    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[NW-2:0], fits};
            rem_reg  <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/core/rrt_isqrt.sv -----
// Iterative integer square root, one root bit per cycle (floor result).
// No package dependencies.
module rrt_isqrt #(
    parameter int RW = 18
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [2*RW-1:0] value,
    output logic            done,
    output logic [RW-1:0]   root
);

    localparam int REM_W = RW + 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [2*RW-1:0]  op_reg;
    logic [REM_W-1:0] rem_reg;
    logic [RW-1:0]    root_reg;
    logic [REM_W+1:0] rem2, trial, diff;
    logic             fits;

    // Bring down two operand bits and try root*4+1.
    always_comb begin
        rem2  = {rem_reg, op_reg[2*RW-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        diff  = rem2 - trial;
        fits  = rem2 >= trial;
    end

    // Step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and root update.
    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg   <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            op_reg   <= {op_reg[2*RW-3:0], 2'b00};
            rem_reg  <= fits ? diff[REM_W-1:0] : rem2[REM_W-1:0];
            root_reg <= {root_reg[RW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
